@@ src/vssd_pkg.sv @@
// Shared types, constants and helpers for the vector segment stream decoder.
package vssd_pkg;

    localparam int HEADER_BYTES = 36;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIM     = 2'd2;

    localparam logic [7:0] RST_OPAQUE_CODE = 8'd0;
    localparam logic [7:0] RST_FLOAT_CODE  = 8'd1;
    localparam logic [7:0] RST_MAX_SIM     = 8'd2;

    localparam logic [1:0] KIND_VEC  = 2'd0;
    localparam logic [1:0] KIND_ID   = 2'd1;
    localparam logic [1:0] KIND_BYTE = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SMALL     = 4'd1;
    localparam logic [3:0] ST_MAGIC     = 4'd2;
    localparam logic [3:0] ST_VERSION   = 4'd3;
    localparam logic [3:0] ST_ENCODING  = 4'd4;
    localparam logic [3:0] ST_SIM       = 4'd5;
    localparam logic [3:0] ST_RESERVED  = 4'd6;
    localparam logic [3:0] ST_OVERFLOW  = 4'd7;
    localparam logic [3:0] ST_VEC_LEN   = 4'd8;
    localparam logic [3:0] ST_SHORT     = 4'd9;
    localparam logic [3:0] ST_FRAME_LEN = 4'd10;
    localparam logic [3:0] ST_TOTAL_LEN = 4'd11;

    // header byte positions
    localparam logic [5:0] POS_VER_HI  = 6'd5;
    localparam logic [5:0] POS_ENC     = 6'd6;
    localparam logic [5:0] POS_SIM     = 6'd7;
    localparam logic [5:0] POS_DIM_END = 6'd11;
    localparam logic [5:0] POS_CNT_END = 6'd19;
    localparam logic [5:0] POS_PAY_END = 6'd27;
    localparam logic [5:0] POS_RSV     = 6'd28;
    localparam logic [5:0] POS_MAGIC_N = 6'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_end;
    } t_in;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [63:0] item_value;
        logic [3:0]  status_code;
        logic        is_float_encoding;
        logic [7:0]  similarity_kind;
        logic [31:0] vector_dimension;
        logic [63:0] vector_total;
        logic        last_item;
    } t_out;

    // record passed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic [3:0]  err;
        logic        fl;
        logic [7:0]  sim;
        logic [31:0] dim;
        logic [63:0] cnt;
        logic [63:0] pay;
        logic [63:0] frm;
        logic [63:0] len;
    } t_rec;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL0,
        B_MUL1,
        B_SUM,
        B_FIN
    } t_bstate;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h4D;
            2'd1:    m = 8'h56;
            2'd2:    m = 8'h32;
            default: m = 8'h56;
        endcase
        return m;
    endfunction

endpackage

@@ src/vssd_front.sv @@
// Front end: config registers, header parse, region tracking, record build.
module vssd_front
    import vssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_rec_valid,
    output t_rec                  o_rec,
    input  logic                  i_rec_ready
);

    logic [7:0]  r_opq, r_flc, r_msim;
    logic [63:0] r_pos, n_pos;
    logic [63:0] r_asm, n_asm;
    logic [31:0] r_dim, n_dim;
    logic [63:0] r_cnt, n_cnt;
    logic [63:0] r_pay, n_pay;
    logic [63:0] r_rem, n_rem;
    logic [3:0]  r_tail, n_tail;
    logic        r_fl, n_fl;
    logic [7:0]  r_sim, n_sim;
    logic [63:0] r_frm, n_frm;
    logic [3:0]  r_err, n_err;

    logic        acc, have;
    logic [1:0]  kind;
    logic [63:0] value;
    logic [3:0]  fcode;
    logic [5:0]  psm;
    logic [7:0]  b;

    assign o_ready = i_rec_ready;
    assign acc     = i_valid && i_rec_ready;
    assign b       = i_data.data_byte;
    assign psm     = r_pos[5:0];

    always_comb begin
        n_pos  = r_pos;
        n_asm  = r_asm;
        n_dim  = r_dim;
        n_cnt  = r_cnt;
        n_pay  = r_pay;
        n_rem  = r_rem;
        n_tail = r_tail;
        n_fl   = r_fl;
        n_sim  = r_sim;
        n_frm  = r_frm;
        n_err  = r_err;
        have   = 1'b0;
        kind   = KIND_VEC;
        value  = 64'd0;
        fcode  = ST_OK;
        if (acc) begin
            n_asm = {b, r_asm[63:8]};
            if (r_pos < 64'(HEADER_BYTES)) begin
                if (psm < POS_MAGIC_N) begin
                    if (b != magic_byte(psm[1:0])) fcode = ST_MAGIC;
                end else if (psm == POS_VER_HI) begin
                    if (n_asm[63:48] != 16'd1) fcode = ST_VERSION;
                end else if (psm == POS_ENC) begin
                    if (b == r_opq) n_fl = 1'b0;
                    else if (b == r_flc) n_fl = 1'b1;
                    else fcode = ST_ENCODING;
                end else if (psm == POS_SIM) begin
                    n_sim = b;
                    if (b > r_msim) fcode = ST_SIM;
                end else if (psm == POS_DIM_END) begin
                    n_dim = n_asm[63:32];
                end else if (psm == POS_CNT_END) begin
                    n_cnt = n_asm;
                end else if (psm == POS_PAY_END) begin
                    n_pay = n_asm;
                    n_rem = n_asm;
                end else if (psm >= POS_RSV) begin
                    if (b != 8'd0) fcode = ST_RESERVED;
                end
            end else if (r_err == ST_OK) begin
                if (!r_fl) begin
                    have  = 1'b1;
                    kind  = KIND_BYTE;
                    value = {56'd0, b};
                end else if (r_rem != 64'd0) begin
                    n_rem = r_rem - 64'd1;
                    // header is word aligned, so byte position bits give the lane
                    if (r_pos[1:0] == 2'd3) begin
                        have  = 1'b1;
                        kind  = KIND_VEC;
                        value = {32'd0, n_asm[63:32]};
                    end
                end else begin
                    if (!r_tail[3]) begin
                        if (r_tail[2:0] == 3'd7) n_frm = n_asm;
                    end else if (r_tail[2:0] == 3'd7) begin
                        have  = 1'b1;
                        kind  = KIND_ID;
                        value = n_asm;
                    end
                    n_tail = (r_tail == 4'd15) ? 4'd8 : r_tail + 4'd1;
                end
            end
            if (r_err == ST_OK && fcode != ST_OK) n_err = fcode;
            n_pos = (r_pos == '1) ? r_pos : r_pos + 64'd1;
        end

        o_rec.kind  = i_data.segment_end ? KIND_END : kind;
        o_rec.value = value;
        o_rec.err   = n_err;
        o_rec.fl    = n_fl;
        o_rec.sim   = n_sim;
        o_rec.dim   = n_dim;
        o_rec.cnt   = n_cnt;
        o_rec.pay   = n_pay;
        o_rec.frm   = n_frm;
        o_rec.len   = n_pos;
        o_rec_valid = i_valid && (have || i_data.segment_end);

        if (acc && i_data.segment_end) begin
            n_pos  = 64'd0;
            n_asm  = 64'd0;
            n_dim  = 32'd0;
            n_cnt  = 64'd0;
            n_pay  = 64'd0;
            n_rem  = 64'd0;
            n_tail = 4'd0;
            n_fl   = 1'b0;
            n_sim  = 8'd0;
            n_frm  = 64'd0;
            n_err  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opq  <= RST_OPAQUE_CODE;
            r_flc  <= RST_FLOAT_CODE;
            r_msim <= RST_MAX_SIM;
            r_pos  <= 64'd0;
            r_asm  <= 64'd0;
            r_dim  <= 32'd0;
            r_cnt  <= 64'd0;
            r_pay  <= 64'd0;
            r_rem  <= 64'd0;
            r_tail <= 4'd0;
            r_fl   <= 1'b0;
            r_sim  <= 8'd0;
            r_frm  <= 64'd0;
            r_err  <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OPAQUE_CODE: r_opq  <= i_cfg_data;
                    CFG_FLOAT_CODE:  r_flc  <= i_cfg_data;
                    CFG_MAX_SIM:     r_msim <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos  <= n_pos;
            r_asm  <= n_asm;
            r_dim  <= n_dim;
            r_cnt  <= n_cnt;
            r_pay  <= n_pay;
            r_rem  <= n_rem;
            r_tail <= n_tail;
            r_fl   <= n_fl;
            r_sim  <= n_sim;
            r_frm  <= n_frm;
            r_err  <= n_err;
        end
    end

endmodule

@@ src/vssd_queue.sv @@
// Short record queue between front and back.
module vssd_queue
    import vssd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rec i_rec,
    output logic o_valid,
    input  logic i_ready,
    output t_rec o_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (push && !pop) r_cnt <= r_cnt + CW'(1);
            else if (pop && !push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

@@ src/vssd_back.sv @@
// Back end: passes items to the output register, computes end status over cycles.
module vssd_back
    import vssd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rec_valid,
    output logic o_rec_ready,
    input  t_rec i_rec,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_bstate     r_st, n_st;
    t_rec        r_rec;
    logic [63:0] r_plo, r_phi;
    logic [64:0] r_m36, r_m44, r_tot;
    logic [63:0] r_vals;
    logic        r_povf;
    logic        r_ov, n_ov;
    t_out        r_out, n_out;
    logic        out_free, take;
    logic [32:0] upper;
    logic [3:0]  st;

    assign out_free    = !r_ov || i_ready;
    assign o_rec_ready = (r_st == B_IDLE) && out_free;
    assign take        = i_rec_valid && o_rec_ready;
    assign o_valid     = r_ov;
    assign o_data      = r_out;
    assign upper       = {1'b0, r_plo[63:32]} + {1'b0, r_phi[31:0]};

    always_comb begin
        if (r_rec.len < 64'(HEADER_BYTES))            st = ST_SMALL;
        else if (r_rec.err != ST_OK)                 st = r_rec.err;
        else if (!r_rec.fl) begin
            if (r_m36[64])                           st = ST_OVERFLOW;
            else if (r_m36[63:0] != r_rec.len)       st = ST_TOTAL_LEN;
            else                                     st = ST_OK;
        end
        else if (r_povf)                             st = ST_OVERFLOW;
        else if (r_vals[63:62] != 2'd0)              st = ST_OVERFLOW;
        else if (r_rec.pay != {r_vals[61:0], 2'b0})  st = ST_VEC_LEN;
        else if (r_m44[64])                          st = ST_OVERFLOW;
        else if (r_rec.len < r_m44[63:0])            st = ST_SHORT;
        else if (r_rec.cnt[63:61] != 3'd0)           st = ST_OVERFLOW;
        else if (r_rec.frm != {r_rec.cnt[60:0], 3'b0}) st = ST_FRAME_LEN;
        else if (r_tot[64])                          st = ST_OVERFLOW;
        else if (r_tot[63:0] != r_rec.len)           st = ST_TOTAL_LEN;
        else                                         st = ST_OK;
    end

    always_comb begin
        n_st  = r_st;
        n_ov  = r_ov && !i_ready;
        n_out = r_out;
        case (r_st)
            B_IDLE: begin
                if (take) begin
                    if (i_rec.kind == KIND_END) begin
                        n_st = B_MUL0;
                    end else begin
                        n_ov  = 1'b1;
                        n_out = '0;
                        n_out.item_kind  = i_rec.kind;
                        n_out.item_value = i_rec.value;
                    end
                end
            end
            B_MUL0: n_st = B_MUL1;
            B_MUL1: n_st = B_SUM;
            B_SUM:  n_st = B_FIN;
            B_FIN: begin
                if (out_free) begin
                    n_st = B_IDLE;
                    n_ov = 1'b1;
                    n_out.item_kind         = KIND_END;
                    n_out.item_value        = r_rec.value;
                    n_out.status_code       = st;
                    n_out.is_float_encoding = r_rec.fl;
                    n_out.similarity_kind   = r_rec.sim;
                    n_out.vector_dimension  = r_rec.dim;
                    n_out.vector_total      = r_rec.cnt;
                    n_out.last_item         = 1'b1;
                end
            end
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    // datapath: count * dimension as two 32x32 partial products
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_st == B_IDLE && take) r_rec <= i_rec;
        if (r_st == B_MUL0) begin
            r_plo <= r_rec.cnt[31:0] * r_rec.dim;
            r_m36 <= {1'b0, r_rec.pay} + 65'(HEADER_BYTES);
            r_m44 <= {1'b0, r_rec.pay} + 65'(HEADER_BYTES + 8);
        end
        if (r_st == B_MUL1) r_phi <= r_rec.cnt[63:32] * r_rec.dim;
        if (r_st == B_SUM) begin
            r_povf <= (r_phi[63:32] != 32'd0) || upper[32];
            r_vals <= {upper[31:0], r_plo[31:0]};
            r_tot  <= {1'b0, r_rec.frm} + {1'b0, r_m44[63:0]};
        end
    end

endmodule

@@ src/vector_segment_stream_decoder_core.sv @@
// Vector segment stream decoder top level.
// Throughput: one byte per cycle while the queue has room; items pass the queue
// and the output register. A segment end holds the back end in B_MUL0, B_MUL1,
// B_SUM and B_FIN (two 32x32 partial products, sum, status compare) for end status.
// Synchronous active-low reset restores register defaults (0, 1, 2) and
// clears all segment state, the queue and the output valid flag.
module vector_segment_stream_decoder_core
    import vssd_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out                  o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic f_valid, f_ready, q_valid, q_ready;
    t_rec f_rec, q_rec;

    vssd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_rec_valid (f_valid),
        .o_rec       (f_rec),
        .i_rec_ready (f_ready)
    );

    vssd_queue #(.DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_rec   (f_rec),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_rec   (q_rec)
    );

    vssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (q_valid),
        .o_rec_ready (q_ready),
        .i_rec       (q_rec),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
